// ----- src/rc_pkg.sv -----
`default_nettype none
package rc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

	localparam logic [VALUE_BITS-1:0] LIMIT       = '1;
	localparam logic [VALUE_BITS-1:0] LIMIT_DIV10 = VALUE_BITS'(LIMIT / 10);

	localparam logic [3:0] BASE_2  = 4'd2;
	localparam logic [3:0] BASE_8  = 4'd8;
	localparam logic [3:0] BASE_10 = 4'd10;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_BASE  = 2'd1,
		ST_SAME_BASE = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [3:0]            divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] quo;
		logic [3:0]            rem;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- src/rc_div.sv -----
`default_nettype none
module rc_div
	import rc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [3:0]            rem_q;
	logic [3:0]            div_q;

	logic [4:0] trial;
	logic       fits;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
				quo_q  <= req.dividend;
				rem_q  <= '0;
				div_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q  <= fits ? 4'(trial - {1'b0, div_q}) : trial[3:0];
				quo_q  <= {quo_q[VALUE_BITS-2:0], fits};
				cnt_q  <= cnt_q - CNT_BITS'(1);
				done_q <= (cnt_q == CNT_BITS'(1));
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

// ----- src/radix_converter_2_8_10_top.sv -----
// A rejected base goes from idle straight to DONE and then to the output register.
// Otherwise each source digit (decimal digit of number_in) and each target digit takes a
// pass on the bit-serial shared divider (issue plus one quotient bit a cycle) and its
// READ or WRITE and WAIT states. Worst case, octal into binary, is 39 digits.
// Throughput: one item at a time; input stalls until done.
// Reset (arst_n, asynchronous, active low) idles the sequencer and drops any result.
`default_nettype none
module radix_converter_2_8_10_top
	import rc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [3:0]            source_base,
	input  wire logic [3:0]            target_base,
	input  wire logic [VALUE_BITS-1:0] number_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [VALUE_BITS-1:0]      number_out,
	output logic [1:0]                 status
);

	// Sequencer phases:
	//   READ  - peel decimal digits off the source by dividing by ten, weight by source base
	//   WRITE - peel target digits off the value by dividing by target base, weight by ten
	//   DONE  - hold the result until the output register is free
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_READ_WAIT,
		S_WRITE,
		S_WRITE_WAIT,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [3:0]            sb_q;
	logic [3:0]            tb_q;
	logic [VALUE_BITS-1:0] v_q;      // value still to be split
	logic [VALUE_BITS-1:0] acc_q;    // packed result so far
	logic [VALUE_BITS-1:0] w_q;      // weight of the next digit
	logic                  wbig_q;   // decimal weight has passed the field
	logic [VALUE_BITS-1:0] res_q;
	status_t               st_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] number_out_q;
	status_t               status_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                  in_xfer;
	logic                  out_free;
	logic                  sb_ok;
	logic                  tb_ok;
	logic [VALUE_BITS+3:0] prod_rw;
	logic [VALUE_BITS+4:0] sum_w;
	logic [VALUE_BITS+3:0] w_mul_sb;
	logic [VALUE_BITS+3:0] w_mul10;
	logic                  ovf;

	rc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		in_xfer  = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		sb_ok    = source_base inside {BASE_2, BASE_8, BASE_10};
		tb_ok    = target_base inside {BASE_2, BASE_8, BASE_10};

		// digit times weight, added to the packed result; also the overflow test
		prod_rw  = (VALUE_BITS+4)'(div_rsp.rem) * (VALUE_BITS+4)'(w_q);
		sum_w    = (VALUE_BITS+5)'(acc_q) + (VALUE_BITS+5)'(prod_rw);
		w_mul_sb = (VALUE_BITS+4)'(w_q) * (VALUE_BITS+4)'(sb_q);
		w_mul10  = (VALUE_BITS+4)'(w_q) * (VALUE_BITS+4)'(BASE_10);
		ovf      = wbig_q || (sum_w > (VALUE_BITS+5)'(LIMIT));

		// kick the shared divider from READ or WRITE while the phase still has digits left
		div_req.start    = ((state_q == S_READ) || (state_q == S_WRITE)) && (v_q != '0);
		div_req.dividend = v_q;
		div_req.divisor  = (state_q == S_READ) ? BASE_10 : tb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sb_q         <= '0;
			tb_q         <= '0;
			v_q          <= '0;
			acc_q        <= '0;
			w_q          <= '0;
			wbig_q       <= 1'b0;
			res_q        <= '0;
			st_q         <= ST_OK;
			out_valid_q  <= 1'b0;
			number_out_q <= '0;
			status_q     <= ST_OK;
		end else begin
			// drop the output once it has been transferred, unless DONE refills it
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						sb_q   <= source_base;
						tb_q   <= target_base;
						v_q    <= number_in;
						acc_q  <= '0;
						w_q    <= VALUE_BITS'(1);
						wbig_q <= 1'b0;
						res_q  <= '0;
						if (!sb_ok || !tb_ok) begin
							st_q    <= ST_BAD_BASE;
							state_q <= S_DONE;
						end else if (source_base == target_base) begin
							st_q    <= ST_SAME_BASE;
							state_q <= S_DONE;
						end else if (source_base == BASE_10) begin
							// already a plain value: go straight to splitting
							st_q    <= ST_OK;
							state_q <= S_WRITE;
						end else begin
							st_q    <= ST_OK;
							state_q <= S_READ;
						end
					end
				end

				S_READ: begin
					if (v_q == '0) begin
						if (tb_q == BASE_10) begin
							res_q   <= acc_q;
							state_q <= S_DONE;
						end else begin
							// restart the accumulators for the write phase
							v_q     <= acc_q;
							acc_q   <= '0;
							w_q     <= VALUE_BITS'(1);
							wbig_q  <= 1'b0;
							state_q <= S_WRITE;
						end
					end else begin
						state_q <= S_READ_WAIT;
					end
				end

				S_READ_WAIT: begin
					if (div_rsp.done) begin
						// the sum never passes the source number, so no overflow here
						acc_q   <= sum_w[VALUE_BITS-1:0];
						v_q     <= div_rsp.quo;
						w_q     <= w_mul_sb[VALUE_BITS-1:0];
						state_q <= S_READ;
					end
				end

				S_WRITE: begin
					if (v_q == '0) begin
						res_q   <= acc_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WRITE_WAIT;
					end
				end

				S_WRITE_WAIT: begin
					if (div_rsp.done) begin
						v_q <= div_rsp.quo;
						if ((div_rsp.rem != '0) && ovf) begin
							res_q   <= LIMIT;
							st_q    <= ST_OVERFLOW;
							state_q <= S_DONE;
						end else begin
							if (div_rsp.rem != '0) begin
								acc_q <= sum_w[VALUE_BITS-1:0];
							end
							// advance the decimal weight; once past the field only flag it
							if (!wbig_q) begin
								if (w_q > LIMIT_DIV10) begin
									wbig_q <= 1'b1;
								end else begin
									w_q <= w_mul10[VALUE_BITS-1:0];
								end
							end
							state_q <= S_WRITE;
						end
					end
				end

				S_DONE: begin
					// hold until the output register is free, then hand the result over
					if (out_free) begin
						number_out_q <= res_q;
						status_q     <= st_q;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign number_out = number_out_q;
	assign status     = status_q;

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import rc_pkg::*;

	// Run bounds. The worst item is octal into binary; the cycle limit allows every item
	// its worst case plus stalls several times.
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 10_000_000;
	localparam int TAIL_CYCLES  = 1500;
	localparam int HOLD_CYCLES  = 600;
	localparam int IDLE_PCT     = 12;

	// One predicted conversion: the packed digits and the status code.
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		status_t               st;
	} conv_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [3:0]            source_base;
	logic [3:0]            target_base;
	logic [VALUE_BITS-1:0] number_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [VALUE_BITS-1:0] number_out;
	logic [1:0]            status;

	// Conversions accepted by the block whose results have not come back yet.
	conv_t pending_convs[$];
	int    mismatches;
	int    cycle_count;
	// Set while neither side idles at random.
	bit    steady;
	// Handed to the receiver process, which counts the hold-off itself.
	int    hold_request;

	radix_converter_2_8_10_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.source_base(source_base),
		.target_base(target_base),
		.number_in  (number_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.number_out (number_out),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Base code for index 0, 1 or 2.
	function automatic logic [3:0] radix_of(input int idx);
		case (idx)
			0:       return BASE_2;
			1:       return BASE_8;
			default: return BASE_10;
		endcase
	endfunction

	function automatic bit legal_radix(input logic [3:0] b);
		return b == BASE_2 || b == BASE_8 || b == BASE_10;
	endfunction

	// Predict the block's result for one request. Source digits are read
	// from the decimal digits of the number and weighted by powers of the
	// source base; the plain value is then split by the target base and
	// packed back as decimal digits, saturating at the field's top.
	function automatic conv_t convert_number(input logic [3:0] src, input logic [3:0] dst,
			input logic [VALUE_BITS-1:0] num);
		longint unsigned top, n, plain, acc, w, r;
		bit w_huge, sat;
		conv_t res;
		top   = LIMIT;
		res.value = '0;
		res.st    = ST_OK;
		if (!legal_radix(src) || !legal_radix(dst)) begin
			res.st = ST_BAD_BASE;
		end else if (src == dst) begin
			res.st = ST_SAME_BASE;
		end else begin
			n = num;
			if (src == BASE_10) begin
				plain = n;
			end else begin
				// Oversized digits are weighted as they stand.
				plain = 0;
				w     = 1;
				while (n != 0) begin
					plain += (n % 10) * w;
					n     /= 10;
					if (n != 0)
						w *= src;
				end
			end
			if (dst == BASE_10) begin
				res.value = plain[VALUE_BITS-1:0];
			end else begin
				acc    = 0;
				w      = 1;
				w_huge = 1'b0;
				sat    = 1'b0;
				while (plain != 0 && !sat) begin
					r      = plain % dst;
					plain /= dst;
					if (r != 0) begin
						if (w_huge || w > (top - acc) / r)
							sat = 1'b1;
						else
							acc += r * w;
					end
					// Stop growing the weight once another decade would pass the top.
					if (!sat && !w_huge) begin
						if (w > top / 10)
							w_huge = 1'b1;
						else
							w *= 10;
					end
				end
				if (sat) begin
					res.value = LIMIT;
					res.st    = ST_OVERFLOW;
				end else begin
					res.value = acc[VALUE_BITS-1:0];
				end
			end
		end
		return res;
	endfunction

	// Build a number whose decimal digits are digits of the given base; with
	// wild set, any decimal digit may appear. Keep the low nine digits when
	// the string would not fit the field.
	function automatic logic [VALUE_BITS-1:0] digit_string(input logic [3:0] radix,
			input int ndig, input bit wild);
		longint unsigned acc;
		int k;
		acc = 0;
		for (k = 0; k < ndig; k++)
			acc = acc * 10 + (wild ? $urandom_range(0, 9) : $urandom_range(0, radix - 1));
		if (acc > LIMIT)
			acc = acc % 1_000_000_000;
		return acc[VALUE_BITS-1:0];
	endfunction

	// Offer one request and hold it until the block takes it. Valid is
	// left high on return so the next request can follow without a gap;
	// an idle cycle or wait_drained lowers it.
	task automatic send_conv(input logic [3:0] src, input logic [3:0] dst,
			input logic [VALUE_BITS-1:0] num);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		source_base <= src;
		target_base <= dst;
		number_in   <= num;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every accepted request has its result.
	task automatic wait_drained;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_convs.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of the number, every base pair, and the rejection, oversized
	// digit, overflow and zero cases.
	task automatic check_directed_cases;
		send_conv(BASE_2,  BASE_8,  31'd1011);
		send_conv(BASE_2,  BASE_10, 31'd1111111111);
		send_conv(BASE_8,  BASE_2,  31'd17);
		send_conv(BASE_8,  BASE_10, 31'd7777);
		send_conv(BASE_10, BASE_2,  31'd1023);
		send_conv(BASE_10, BASE_8,  LIMIT);
		// zero in and out
		send_conv(BASE_2,  BASE_8,  '0);
		send_conv(BASE_10, BASE_2,  '0);
		// equal bases
		send_conv(BASE_2,  BASE_2,  31'd101);
		send_conv(BASE_8,  BASE_8,  31'd777);
		send_conv(BASE_10, BASE_10, LIMIT);
		// bad source base is tested before the target; equal bad bases too
		send_conv(4'd0,    BASE_2,  31'd5);
		send_conv(4'd15,   BASE_8,  31'd5);
		send_conv(4'd3,    BASE_10, 31'd5);
		send_conv(BASE_2,  4'd15,   31'd1);
		send_conv(BASE_10, 4'd0,    31'd9);
		send_conv(4'd5,    4'd5,    31'd5);
		// oversized digits for the source base
		send_conv(BASE_8,  BASE_2,  31'd99);
		send_conv(BASE_2,  BASE_10, LIMIT);
		send_conv(BASE_8,  BASE_10, 31'd1999999999);
		// packed binary digits past the field top
		send_conv(BASE_10, BASE_2,  31'd1024);
		send_conv(BASE_10, BASE_2,  LIMIT);
		send_conv(BASE_8,  BASE_2,  31'd7777777);
		wait_drained();
	endtask

	// Hold the receiver off for a long stretch while requests keep coming,
	// so the block stalls its input with a finished result waiting.
	task automatic check_backpressure;
		int k;
		steady       = 1'b1;
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 8; k++)
			send_conv(BASE_10, BASE_8, VALUE_BITS'($urandom_range(0, 999)));
		steady = 1'b0;
		wait_drained();
	endtask

	// Mostly well-formed requests with random content; the rest oversized
	// digits, equal bases, arbitrary base codes and arbitrary numbers.
	// Pause the sender halfway until every result is back, and run one
	// stretch with no idling on either side.
	task automatic check_random_traffic;
		int k, kind, si, di, ndig;
		logic [3:0] src, dst;
		logic [VALUE_BITS-1:0] num;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2)
				wait_drained();
			steady = (k >= 300 && k < 450);
			kind   = $urandom_range(0, 99);
			si     = $urandom_range(0, 2);
			di     = (si + $urandom_range(1, 2)) % 3;
			src    = radix_of(si);
			dst    = radix_of(di);
			// Keep most numbers short so most items finish quickly.
			ndig   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 10);
			if (kind < 70) begin
				num = digit_string(src, ndig, 1'b0);
			end else if (kind < 78) begin
				num = digit_string(src, ndig, 1'b1);
			end else if (kind < 84) begin
				dst = src;
				num = digit_string(src, ndig, 1'b0);
			end else if (kind < 92) begin
				src = 4'($urandom_range(0, 15));
				dst = 4'($urandom_range(0, 15));
				num = VALUE_BITS'($urandom());
			end else begin
				num = VALUE_BITS'($urandom());
			end
			send_conv(src, dst, num);
		end
		steady = 1'b0;
		wait_drained();
	endtask

	// Predict each request at the edge where the block takes it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pending_convs.push_back(convert_number(source_base, target_base, number_in));
	end

	// Compare each transferred result with the oldest prediction.
	always @(posedge clk) begin : check_result
		conv_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_convs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: result with none pending: number_out %0d status %0d",
						number_out, status);
			end else begin
				want = pending_convs.pop_front();
				if (number_out !== want.value || status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: number_out exp %0d got %0d, status exp %0d got %0d",
							want.value, number_out, want.st, status);
				end
			end
		end
	end

	// Receiver: stall at random, or for a requested hold-off counted here.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Timeout: end the run if it goes far past the slowest correct run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		source_base  = '0;
		target_base  = '0;
		number_in    = '0;
		mismatches   = 0;
		steady       = 1'b0;
		hold_request = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_directed_cases();
		check_backpressure();
		check_random_traffic();

		// Let any stray result show up before judging.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_convs.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
